FILE: design/twle_pkg.sv
package twle_pkg;

    localparam int COLUMNS = 40;
    localparam int ROWS = 25;
    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = 6;
    localparam int RW = 5;

    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] KEY_RETURN = 8'd13;
    localparam logic [7:0] KEY_STOP = 8'd3;
    localparam logic [7:0] KEY_HOME = 8'd19;
    localparam logic [7:0] KEY_CLEAR = 8'd147;
    localparam logic [7:0] KEY_DOWN = 8'd17;
    localparam logic [7:0] KEY_UP = 8'd145;
    localparam logic [7:0] KEY_RIGHT = 8'd29;
    localparam logic [7:0] KEY_LEFT = 8'd157;
    localparam logic [7:0] KEY_DEL = 8'd20;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] key_code;
        logic [5:0] read_column;
        logic [4:0] read_row;
    } t_in;

    typedef struct packed {
        logic       line_done;
        logic [5:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
    } t_out;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CLEAR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_TAIL,
        ST_OUT
    } t_state;

    function automatic logic [7:0] to_screen(input logic [7:0] c);
        logic [7:0] m;
        case (c[7:5])
            3'd2: m = 8'h40;
            3'd3: m = 8'h20;
            3'd4: m = 8'h80;
            3'd5: m = 8'hc0;
            3'd6: m = 8'h80;
            3'd7: m = 8'h80;
            default: m = 8'h00;
        endcase
        return c ^ m;
    endfunction

    function automatic logic [7:0] to_char(input logic [7:0] s);
        logic [7:0] m;
        case (s[7:5])
            3'd0: m = 8'h40;
            3'd1: m = 8'h00;
            3'd2: m = 8'h20;
            3'd3: m = 8'hc0;
            3'd4: m = 8'hc0;
            3'd5: m = 8'h80;
            3'd6: m = 8'ha0;
            default: m = 8'h40;
        endcase
        return s ^ m;
    endfunction

endpackage

FILE: design/twle_ram.sv
module twle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/text_window_line_editor.sv
// Text window line editor.
// Input channel: i_in_valid / o_in_stall with payload i_in (action, key code,
// read position). Output channel: o_out_valid / i_out_stall with payload o_out,
// one result item per input item, in order.
// Configuration: i_cfg_valid / o_cfg_ready, i_cfg_index 0 = window columns,
// 1 = window rows; writes are taken whenever the channel is valid.
// The screen lives in one 1000 x 8 single-port-write RAM with registered read.
// Cursor and line-done keys go from decode straight to output; a read adds a
// RAM read state. Insert and delete shift the cells behind the cursor one at a
// time, each with a read, then a write, and end with one tail write.
// Clear writes one window cell a cycle.
// After reset the block sweeps the whole RAM with spaces and holds o_in_stall
// high meanwhile; cursor returns to the top left corner and the window to
// 40 x 25.
// One item is in work at a time; o_in_stall stays high from acceptance until
// its result has been taken. A stalled result holds in the output register.
module text_window_line_editor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  twle_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output twle_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [5:0]      i_cfg_data
);
    import twle_pkg::*;

    t_state r_state, n_state;
    logic [5:0] r_wcols;
    logic [4:0] r_wrows;
    logic [CW-1:0] r_cx, n_cx;
    logic [RW-1:0] r_cy, n_cy;
    t_in r_item;
    t_out r_out;
    logic [AW-1:0] r_init;
    // shift walk: r_pc/r_pr is destination cell, r_ec/r_er the end cell
    logic [CW-1:0] r_pc, r_ec;
    logic [RW-1:0] r_pr, r_er;
    logic r_dir_ins;
    logic [7:0] r_ins_code;

    logic [CW-1:0] wx;
    logic [RW-1:0] wy;
    logic [CW-1:0] cx;
    logic [RW-1:0] cy;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;

    twle_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        wx = (r_wcols == '0) ? CW'(1) : (r_wcols > CW'(COLUMNS)) ? CW'(COLUMNS) : r_wcols;
        wy = (r_wrows == '0) ? RW'(1) : (r_wrows > RW'(ROWS)) ? RW'(ROWS) : r_wrows;
        cx = (r_cx >= wx) ? wx - CW'(1) : r_cx;
        cy = (r_cy >= wy) ? wy - RW'(1) : r_cy;
    end

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(r * COLUMNS) + AW'(c);
    endfunction

    // neighbor cells in window order
    logic [CW-1:0] nx_c, pv_c;
    logic [RW-1:0] nx_r, pv_r;
    logic at_end;
    always_comb begin
        if (r_pc + CW'(1) < wx) begin
            nx_c = r_pc + CW'(1); nx_r = r_pr;
        end else begin
            nx_c = '0; nx_r = r_pr + RW'(1);
        end
        if (r_pc != '0) begin
            pv_c = r_pc - CW'(1); pv_r = r_pr;
        end else begin
            pv_c = wx - CW'(1); pv_r = r_pr - RW'(1);
        end
        at_end = (r_pc == r_ec) && (r_pr == r_er);
    end

    logic in_acc;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out = r_out;
    assign o_out_valid = (r_state == ST_OUT);

    logic key_print, can_ins;
    always_comb begin
        key_print = ((r_item.key_code >= 8'd32) && (r_item.key_code < 8'd128))
                 || (r_item.key_code >= 8'd160);
        can_ins = (cy + RW'(1) < wy) || (cx + CW'(1) < wx);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: if (r_init == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE: if (in_acc) n_state = ST_DECODE;
            ST_DECODE: begin
                if (r_item.action) n_state = ST_READ;
                else begin
                    case (r_item.key_code)
                        KEY_CLEAR: n_state = ST_CLEAR;
                        KEY_DEL: n_state = (cx != '0 || cy != '0) ? ST_SHIFT_RD : ST_OUT;
                        default: n_state = (key_print && can_ins) ? ST_SHIFT_RD : ST_OUT;
                    endcase
                end
            end
            ST_READ: n_state = ST_OUT;
            ST_CLEAR: if (at_end) n_state = ST_OUT;
            ST_SHIFT_RD: n_state = at_end ? ST_TAIL : ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_TAIL: n_state = ST_OUT;
            ST_OUT: if (!i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_INIT;
        endcase
    end

    // memory control and cursor
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = addr_of(r_pr, r_pc);
        ram_wdata = SPACE_CODE;
        ram_raddr = r_dir_ins ? addr_of(pv_r, pv_c) : addr_of(nx_r, nx_c);
        n_cx = r_cx;
        n_cy = r_cy;
        unique case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                ram_waddr = r_init;
            end
            ST_DECODE: begin
                ram_raddr = addr_of(r_item.read_row, r_item.read_column);
                n_cx = cx;
                n_cy = cy;
                if (!r_item.action) begin
                    case (r_item.key_code)
                        KEY_HOME, KEY_CLEAR: begin
                            n_cx = '0; n_cy = '0;
                        end
                        KEY_DOWN: if (cy + RW'(1) < wy) n_cy = cy + RW'(1);
                        KEY_UP: if (cy != '0) n_cy = cy - RW'(1);
                        KEY_RIGHT: begin
                            if (cx + CW'(1) < wx) n_cx = cx + CW'(1);
                            else if (cy + RW'(1) < wy) begin
                                n_cx = '0; n_cy = cy + RW'(1);
                            end
                        end
                        KEY_LEFT, KEY_DEL: begin
                            if (cx != '0) n_cx = cx - CW'(1);
                            else if (cy != '0) begin
                                n_cx = wx - CW'(1); n_cy = cy - RW'(1);
                            end
                        end
                        default: begin
                            if (key_print && can_ins) begin
                                if (cx + CW'(1) < wx) n_cx = cx + CW'(1);
                                else begin
                                    n_cx = '0; n_cy = cy + RW'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            ST_CLEAR: ram_we = 1'b1;
            ST_SHIFT_WR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_TAIL: begin
                ram_we = 1'b1;
                ram_wdata = r_dir_ins ? r_ins_code : SPACE_CODE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_init <= '0;
            r_wcols <= 6'd40;
            r_wrows <= 5'd25;
            r_cx <= '0;
            r_cy <= '0;
        end else begin
            r_state <= n_state;
            r_cx <= n_cx;
            r_cy <= n_cy;
            if (r_state == ST_INIT) r_init <= r_init + AW'(1);
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_COLUMNS) r_wcols <= i_cfg_data;
                else r_wrows <= i_cfg_data[4:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) r_item <= i_in;
        unique case (r_state)
            ST_DECODE: begin
                r_out.line_done <= !r_item.action &&
                    (r_item.key_code == KEY_RETURN || r_item.key_code == KEY_STOP);
                r_out.cursor_column <= n_cx;
                r_out.cursor_row <= n_cy;
                r_out.cell_char <= '0;
                r_ins_code <= to_screen(r_item.key_code);
                if (r_item.key_code == KEY_CLEAR) begin
                    r_dir_ins <= 1'b0;
                    r_pc <= '0; r_pr <= '0;
                    r_ec <= wx - CW'(1); r_er <= wy - RW'(1);
                end else if (r_item.key_code == KEY_DEL) begin
                    // walk forward from the cell before the cursor in window order
                    r_dir_ins <= 1'b0;
                    r_pc <= n_cx; r_pr <= n_cy;
                    r_ec <= wx - CW'(1); r_er <= wy - RW'(1);
                end else begin
                    // walk backward from the last cell down to the cursor
                    r_dir_ins <= 1'b1;
                    r_pc <= wx - CW'(1); r_pr <= wy - RW'(1);
                    r_ec <= cx; r_er <= cy;
                end
            end
            ST_READ: begin
                if (r_item.read_column < CW'(COLUMNS) && r_item.read_row < RW'(ROWS))
                    r_out.cell_char <= to_char(ram_rdata);
            end
            ST_CLEAR: begin
                r_pc <= nx_c; r_pr <= nx_r;
            end
            ST_SHIFT_WR: begin
                if (r_dir_ins) begin
                    r_pc <= pv_c; r_pr <= pv_r;
                end else begin
                    r_pc <= nx_c; r_pr <= nx_r;
                end
            end
            default: ;
        endcase
    end

    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");
    a_write_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && r_state != ST_INIT |-> r_pc < wx && r_pr < wy)
        else $error("write outside window");
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> r_out.cursor_column < wx && r_out.cursor_row < wy)
        else $error("cursor outside window");
endmodule
